// ----- sv/ofg_pkg.sv -----
`default_nettype none

package ofg_pkg;

	localparam int unsigned FREQ_BITS_DEF = 22;
	localparam int unsigned LOAD_BITS     = 7;
	localparam int unsigned MARGIN_BITS   = 4;
	localparam int unsigned FUNC_BITS     = 2;
	localparam int unsigned CFG_IDX_BITS  = 3;

	localparam logic [LOAD_BITS-1:0]   PCT_FULL      = 7'd100;
	localparam logic [LOAD_BITS-1:0]   UP_THR_RST    = 7'd90;
	localparam logic [MARGIN_BITS-1:0] DN_MARGIN_RST = 4'd10;
	localparam int unsigned            FREQ_RST_KHZ  = 312000;

	localparam logic [FUNC_BITS-1:0] FUNC_SAMPLE = 2'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_LIMITS = 2'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_START  = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_UP_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DOWN_MARGIN  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DESIRED_HIGH = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_KHZ      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_KHZ      = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FLOOR_KHZ    = 3'd5;

endpackage

`default_nettype wire

// ----- sv/ofg_if.sv -----
`default_nettype none

interface ofg_in_if #(
	parameter int unsigned FREQ_BITS = ofg_pkg::FREQ_BITS_DEF
);
	logic                            valid;
	logic                            ready;
	logic [ofg_pkg::FUNC_BITS-1:0]   func;
	logic                            load_ok;
	logic [ofg_pkg::LOAD_BITS-1:0]   load_pct;
	logic [FREQ_BITS-1:0]            cur_khz;

	modport source (output valid, func, load_ok, load_pct, cur_khz, input ready);
	modport sink (input valid, func, load_ok, load_pct, cur_khz, output ready);
endinterface

interface ofg_out_if #(
	parameter int unsigned FREQ_BITS = ofg_pkg::FREQ_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic                 req_valid;
	logic [FREQ_BITS-1:0] target_khz;
	logic                 pick_highest;

	modport source (output valid, req_valid, target_khz, pick_highest, input ready);
	modport sink (input valid, req_valid, target_khz, pick_highest, output ready);
endinterface

`default_nettype wire

// ----- sv/ofg_div.sv -----
`default_nettype none

module ofg_div #(
	parameter int unsigned NUM_BITS = ofg_pkg::FREQ_BITS_DEF + ofg_pkg::LOAD_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [NUM_BITS-1:0]               dividend,
	input  wire logic [ofg_pkg::LOAD_BITS-1:0]     divisor,
	output logic                                   busy,
	output logic                                   done,
	output logic [NUM_BITS-1:0]                    quotient
);

	localparam int unsigned CNT_BITS = $clog2(NUM_BITS + 1);
	localparam int unsigned LB       = ofg_pkg::LOAD_BITS;

	logic [LB-1:0]       rem_q;
	logic [LB-1:0]       div_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                done_q;

	logic [LB:0] trial;
	logic [LB:0] trial_sub;
	logic        fits;

	// one quotient bit per cycle, dividend bits shift out as quotient bits shift in
	assign trial     = {rem_q, quo_q[NUM_BITS-1]};
	assign fits      = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == CNT_BITS'(1));
			if (start) begin
				cnt_q <= CNT_BITS'(NUM_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial_sub[LB-1:0] : trial[LB-1:0];
			quo_q <= {quo_q[NUM_BITS-2:0], fits};
		end
	end

	assign busy     = cnt_q != '0;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- sv/ondemand_freq_governor_top.sv -----
`default_nettype none
// Limits, start, no-request and fixed-target items go from idle to the output state, then into the
// output register. Items that scale a frequency by load pass the multiply and divide states first;
// the divide state runs the shared one-bit-per-cycle restoring divider. Output waits on out_ch.ready.
// Throughput: one item at a time; input ready only while the sequencer is idle.
// Reset (arst_n low, asynchronous): configuration registers to their defaults, raise flag cleared,
// output empty.

module ondemand_freq_governor_top #(
	parameter int unsigned FREQ_BITS = ofg_pkg::FREQ_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	ofg_in_if.sink                                 in_ch,
	ofg_out_if.source                              out_ch,
	input  wire logic                              cfg_we,
	input  wire logic [ofg_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  wire logic [FREQ_BITS-1:0]              cfg_data
);

	localparam int unsigned LB       = ofg_pkg::LOAD_BITS;
	localparam int unsigned MB       = ofg_pkg::MARGIN_BITS;
	localparam int unsigned NUM_BITS = FREQ_BITS + LB;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;

	logic [LB-1:0]        up_thr_q;
	logic [MB-1:0]        dn_margin_q;
	logic [FREQ_BITS-1:0] desired_q;
	logic [FREQ_BITS-1:0] min_q;
	logic [FREQ_BITS-1:0] max_q;
	logic [FREQ_BITS-1:0] floor_q;
	logic                 raised_q;

	logic [FREQ_BITS-1:0] op_a_q;
	logic [LB-1:0]        load_q;
	logic [LB-1:0]        divisor_q;
	logic                 clamp_q;
	logic                 res_req_q;
	logic [FREQ_BITS-1:0] res_tgt_q;
	logic                 res_high_q;

	logic                 out_valid_q;
	logic                 out_req_q;
	logic [FREQ_BITS-1:0] out_tgt_q;
	logic                 out_high_q;

	logic                 accept;
	logic                 out_load;
	logic [LB-1:0]        load_sat;
	logic [LB-1:0]        diff;
	logic                 dec_div;
	logic                 dec_req;
	logic [FREQ_BITS-1:0] dec_tgt;
	logic                 dec_high;
	logic                 dec_set;
	logic                 dec_clr;
	logic                 dec_clamp;
	logic [FREQ_BITS-1:0] dec_opa;
	logic [LB-1:0]        dec_divisor;

	logic                 div_start;
	logic                 div_busy;
	logic                 div_done;
	logic [NUM_BITS-1:0]  div_dividend;
	logic [NUM_BITS-1:0]  div_quot;
	logic [FREQ_BITS-1:0] quot;
	logic [FREQ_BITS-1:0] clamp_min;
	logic [FREQ_BITS-1:0] clamp_fin;

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ch.ready);

	assign in_ch.ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_thr_q    <= ofg_pkg::UP_THR_RST;
			dn_margin_q <= ofg_pkg::DN_MARGIN_RST;
			desired_q   <= FREQ_BITS'(ofg_pkg::FREQ_RST_KHZ);
			min_q       <= '0;
			max_q       <= FREQ_BITS'(ofg_pkg::FREQ_RST_KHZ);
			floor_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				ofg_pkg::CFG_UP_THRESHOLD: up_thr_q    <= cfg_data[LB-1:0];
				ofg_pkg::CFG_DOWN_MARGIN:  dn_margin_q <= cfg_data[MB-1:0];
				ofg_pkg::CFG_DESIRED_HIGH: desired_q   <= cfg_data;
				ofg_pkg::CFG_MIN_KHZ:      min_q       <= cfg_data;
				ofg_pkg::CFG_MAX_KHZ:      max_q       <= cfg_data;
				ofg_pkg::CFG_FLOOR_KHZ:    floor_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign load_sat = (in_ch.load_pct > ofg_pkg::PCT_FULL) ? ofg_pkg::PCT_FULL : in_ch.load_pct;
	assign diff     = (up_thr_q > LB'(dn_margin_q)) ? (up_thr_q - LB'(dn_margin_q)) : '0;

	always_comb begin
		dec_div     = 1'b0;
		dec_req     = 1'b0;
		dec_tgt     = '0;
		dec_high    = 1'b0;
		dec_set     = 1'b0;
		dec_clr     = 1'b0;
		dec_clamp   = 1'b0;
		dec_opa     = max_q;
		dec_divisor = ofg_pkg::PCT_FULL;
		case (in_ch.func)
			ofg_pkg::FUNC_SAMPLE: begin
				if (in_ch.load_ok) begin
					if (load_sat >= up_thr_q) begin
						dec_set = 1'b1;
						if (raised_q) begin
							dec_req  = 1'b1;
							dec_tgt  = max_q;
							dec_high = 1'b1;
						end else if (in_ch.cur_khz == min_q) begin
							dec_req = 1'b1;
							dec_tgt = desired_q;
						end else begin
							dec_div = 1'b1;
						end
					end else if (in_ch.cur_khz != min_q
							&& !(floor_q != '0 && in_ch.cur_khz == floor_q)
							&& diff != '0 && load_sat < diff) begin
						// lower: cur * load / diff, then clamp
						dec_div     = 1'b1;
						dec_clr     = 1'b1;
						dec_clamp   = 1'b1;
						dec_opa     = in_ch.cur_khz;
						dec_divisor = diff;
					end
				end
			end
			ofg_pkg::FUNC_LIMITS: begin
				if (max_q < in_ch.cur_khz) begin
					dec_req  = 1'b1;
					dec_tgt  = max_q;
					dec_high = 1'b1;
				end else if (min_q > in_ch.cur_khz) begin
					dec_req = 1'b1;
					dec_tgt = min_q;
				end else if (floor_q != '0 && in_ch.cur_khz < floor_q) begin
					dec_req = 1'b1;
					dec_tgt = floor_q;
				end
			end
			ofg_pkg::FUNC_START: begin
				dec_clr = in_ch.cur_khz != '0;
			end
			default: ;
		endcase
	end

	assign div_start    = state_q == S_MUL;
	assign div_dividend = NUM_BITS'(op_a_q) * NUM_BITS'(load_q);
	assign quot         = div_quot[FREQ_BITS-1:0];
	assign clamp_min    = (clamp_q && quot < min_q) ? min_q : quot;
	assign clamp_fin    = (clamp_q && floor_q != '0 && clamp_min < floor_q) ? floor_q : clamp_min;

	ofg_div #(
		.NUM_BITS (NUM_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (divisor_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			raised_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (dec_set) begin
							raised_q <= 1'b1;
						end else if (dec_clr) begin
							raised_q <= 1'b0;
						end
						state_q <= dec_div ? S_MUL : S_OUT;
					end
				end
				S_MUL: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_a_q     <= dec_opa;
			load_q     <= load_sat;
			divisor_q  <= dec_divisor;
			clamp_q    <= dec_clamp;
			res_req_q  <= dec_req;
			res_tgt_q  <= dec_tgt;
			res_high_q <= dec_high;
		end else if (state_q == S_DIV && div_done) begin
			res_req_q  <= 1'b1;
			res_tgt_q  <= clamp_fin;
			res_high_q <= 1'b0;
		end
		if (out_load) begin
			out_req_q  <= res_req_q;
			out_tgt_q  <= res_tgt_q;
			out_high_q <= res_high_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.req_valid    = out_req_q;
	assign out_ch.target_khz   = out_tgt_q;
	assign out_ch.pick_highest = out_high_q;

`ifndef NO_ASSERTIONS
	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_busy)
		else $error("divider busy while sequencer idle");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider done outside divide state");

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ch.ready)
		else $error("input still ready after accepting an item");

	a_out_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("output register not valid after load");
`endif

endmodule

`default_nettype wire
